// ===== rtl/dqr_pkg.sv =====
// dqr_pkg: shared constants, operation codes and payload types for the ring deque
// no dependencies; imported by dqr_ctrl, dqr_datapath and double_ended_queue_ring_unit
package dqr_pkg;

  // ring store geometry
  localparam int DEPTH  = 16;
  localparam int DATA_W = 32;
  localparam int IDX_W  = $clog2(DEPTH);
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int CAP_W  = 5;
  localparam int KIND_W = 2;

  // capacity after reset
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // operation codes
  localparam logic [KIND_W-1:0] KIND_PUSH_FRONT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PUSH_REAR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_POP_FRONT  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_POP_REAR   = 2'd3;

  // register indexes
  localparam int REG_CAPACITY = 0;

  // input item
  typedef struct packed {
    logic [KIND_W-1:0]        kind;
    logic signed [DATA_W-1:0] push_value;
  } dqr_in_t;

  // result item
  typedef struct packed {
    logic                     done_res;
    logic signed [DATA_W-1:0] front_value;
    logic signed [DATA_W-1:0] rear_value;
    logic                     is_empty;
    logic                     is_full;
  } dqr_out_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic load;   // capture the accepted item
    logic exec;   // update pointers, occupancy, write the store
    logic rd;     // registered read of front and rear entries
    logic show;   // result transfer cycle
  } dqr_cmd_t;

endpackage

// ===== rtl/dqr_ctrl.sv =====
// dqr_ctrl: sequencer for the ring deque, one item through exec, read and result steps
// depends on dqr_pkg (command struct)
module dqr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  output dqr_pkg::dqr_cmd_t cmd
);
  import dqr_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_EXEC = 2'd1;
  localparam logic [1:0] ST_RD   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       accept;

  // a new item may enter while the previous result is shown
  assign busy   = (state_r == ST_EXEC) || (state_r == ST_RD);
  assign accept = start && !busy;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (accept) state_nxt = ST_EXEC;
      ST_EXEC: state_nxt = ST_RD;
      ST_RD:   state_nxt = ST_OUT;
      ST_OUT:  state_nxt = accept ? ST_EXEC : ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // command decode
  always_comb begin
    cmd.load = accept;
    cmd.exec = (state_r == ST_EXEC);
    cmd.rd   = (state_r == ST_RD);
    cmd.show = (state_r == ST_OUT);
  end

  // sequence checks
  a_exec_then_rd: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.exec |=> cmd.rd) else $error("exec step not followed by read step");
  a_rd_then_show: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.rd |=> cmd.show) else $error("read step not followed by result");
  a_load_then_exec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> cmd.exec) else $error("accepted item not executed");
  a_one_step: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.exec, cmd.rd, cmd.show})) else $error("overlapping steps");

endmodule

// ===== rtl/dqr_datapath.sv =====
// dqr_datapath: ring store, head/tail pointers, occupancy and capacity register
// depends on dqr_pkg (constants, payload and command types)
module dqr_datapath (
  input  logic                        clk,
  input  logic                        rst_n,
  input  dqr_pkg::dqr_cmd_t           cmd,
  input  dqr_pkg::dqr_in_t            in_data,
  input  logic                        cfg_we,
  input  logic [dqr_pkg::CAP_W-1:0]   cfg_cap,
  output logic [dqr_pkg::CAP_W-1:0]   capacity,
  output dqr_pkg::dqr_out_t           out_data
);
  import dqr_pkg::*;

  logic [DATA_W-1:0] ring_mem [DEPTH];

  dqr_in_t           op_r;
  logic [CAP_W-1:0]  capacity_r;
  logic [IDX_W-1:0]  head_r, head_nxt;
  logic [IDX_W-1:0]  tail_r, tail_nxt;
  logic [CNT_W-1:0]  occ_r, occ_nxt;
  logic              done_r, done_nxt;
  logic [DATA_W-1:0] front_rd_r;
  logic [DATA_W-1:0] rear_rd_r;

  logic [CNT_W-1:0]  cap_eff;
  logic [CNT_W-1:0]  cap_m1;
  logic [CNT_W-1:0]  head_inc;
  logic [CNT_W-1:0]  tail_inc;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  logic              is_push;

  // effective capacity: zero acts as one, clamp to the built depth
  always_comb begin
    priority if (capacity_r == '0) begin
      cap_eff = CNT_W'(1);
    end else if (32'(capacity_r) > 32'(DEPTH)) begin
      cap_eff = CNT_W'(DEPTH);
    end else begin
      cap_eff = CNT_W'(capacity_r);
    end
  end

  assign cap_m1   = cap_eff - CNT_W'(1);
  assign head_inc = CNT_W'(head_r) + CNT_W'(1);
  assign tail_inc = CNT_W'(tail_r) + CNT_W'(1);
  assign is_push  = (op_r.kind == KIND_PUSH_FRONT) || (op_r.kind == KIND_PUSH_REAR);

  // pointer and occupancy update for one operation
  always_comb begin
    head_nxt = head_r;
    tail_nxt = tail_r;
    occ_nxt  = occ_r;
    done_nxt = 1'b0;
    wr_en    = 1'b0;
    wr_addr  = '0;
    if (is_push) begin
      if (occ_r < cap_eff) begin
        if (occ_r == '0) begin
          head_nxt = '0;
          tail_nxt = '0;
          wr_addr  = '0;
        end else if (op_r.kind == KIND_PUSH_FRONT) begin
          head_nxt = (head_r == '0) ? IDX_W'(cap_m1) : head_r - IDX_W'(1);
          wr_addr  = head_nxt;
        end else begin
          tail_nxt = (tail_inc >= cap_eff) ? '0 : IDX_W'(tail_inc);
          wr_addr  = tail_nxt;
        end
        wr_en    = 1'b1;
        occ_nxt  = occ_r + CNT_W'(1);
        done_nxt = 1'b1;
      end
    end else begin
      if (occ_r != '0) begin
        if (occ_r == CNT_W'(1)) begin
          head_nxt = '0;
          tail_nxt = '0;
        end else if (op_r.kind == KIND_POP_FRONT) begin
          head_nxt = (head_inc >= cap_eff) ? '0 : IDX_W'(head_inc);
        end else begin
          tail_nxt = (tail_r == '0) ? IDX_W'(cap_m1) : tail_r - IDX_W'(1);
        end
        occ_nxt  = occ_r - CNT_W'(1);
        done_nxt = 1'b1;
      end
    end
  end

  // control state: pointers, occupancy, capacity
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      capacity_r <= CAP_RESET;
    end else if (cfg_we) begin
      head_r     <= '0;
      tail_r     <= '0;
      occ_r      <= '0;
      capacity_r <= cfg_cap;
    end else if (cmd.exec) begin
      head_r <= head_nxt;
      tail_r <= tail_nxt;
      occ_r  <= occ_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r <= in_data;
    end
    if (cmd.exec) begin
      done_r <= done_nxt;
    end
  end

  // ring store: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (cmd.exec && wr_en) begin
      ring_mem[wr_addr] <= op_r.push_value;
    end
    if (cmd.rd) begin
      front_rd_r <= ring_mem[head_r];
      rear_rd_r  <= ring_mem[tail_r];
    end
  end

  // result assembly, empty queue reads as all ones
  always_comb begin
    out_data.done_res    = done_r;
    out_data.is_empty    = (occ_r == '0);
    out_data.is_full     = (occ_r == cap_eff);
    out_data.front_value = (occ_r == '0) ? '1 : front_rd_r;
    out_data.rear_value  = (occ_r == '0) ? '1 : rear_rd_r;
  end

  assign capacity = capacity_r;

  // ring invariants
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= cap_eff) else $error("occupancy above capacity");
  a_head_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(head_r) < cap_eff) else $error("head outside ring");
  a_tail_bound: assert property (@(posedge clk) disable iff (!rst_n)
    CNT_W'(tail_r) < cap_eff) else $error("tail outside ring");
  a_single_entry: assert property (@(posedge clk) disable iff (!rst_n)
    (occ_r == CNT_W'(1)) |-> (head_r == tail_r)) else $error("single entry, pointers differ");

endmodule

// ===== rtl/double_ended_queue_ring_unit.sv =====
// double_ended_queue_ring_unit: ring-store deque with register port and command interface
// depends on dqr_pkg, dqr_ctrl, dqr_datapath
// sequence: a taken start steps through the exec, read and result states; out_valid is the result strobe
// start is taken again in the result cycle; busy holds it off during the exec and read states,
//   which cover the pointer update followed by the registered read of the ring store
// reset: synchronous, clears pointers and occupancy, capacity to 16; store is not cleared
// results are shown for one cycle only, the receiver cannot stall
module double_ended_queue_ring_unit (
  input  logic                       clk,
  input  logic                       rst_n,
  // command channel
  input  logic                       start,
  output logic                       busy,
  input  dqr_pkg::dqr_in_t           in_data,
  output logic                       out_valid,
  output dqr_pkg::dqr_out_t          out_data,
  // register port
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [1:0]                 paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import dqr_pkg::*;

  dqr_cmd_t         cmd;
  logic             cfg_transfer;
  logic             cfg_we;
  logic [CAP_W-1:0] capacity;
  logic             sel_cap;

  // register decode
  assign pready       = 1'b1;
  assign sel_cap      = (paddr == 2'(REG_CAPACITY * 4));
  assign cfg_transfer = psel && penable && pwrite && pready;
  assign cfg_we       = cfg_transfer && sel_cap;
  assign prdata       = sel_cap ? 32'(capacity) : '0;

  dqr_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  dqr_datapath u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (cmd),
    .in_data  (in_data),
    .cfg_we   (cfg_we),
    .cfg_cap  (pwdata[CAP_W-1:0]),
    .capacity (capacity),
    .out_data (out_data)
  );

  assign out_valid = cmd.show;

endmodule

// ===== tb/double_ended_queue_ring_unit_tb.sv =====
// double_ended_queue_ring_unit_tb: self-checking bench for the ring deque unit
// depends on dqr_pkg and double_ended_queue_ring_unit; a local deque mirror predicts each result
module double_ended_queue_ring_unit_tb;
  import dqr_pkg::*;

  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 6;

  // clock, reset and block inputs, all known from time zero
  logic        clk     = 1'b0;
  logic        rst_n   = 1'b0;
  logic        start   = 1'b0;
  dqr_in_t     in_data = '0;
  logic        psel    = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite  = 1'b0;
  logic [1:0]  paddr   = '0;
  logic [31:0] pwdata  = '0;
  logic        busy;
  logic        out_valid;
  dqr_out_t    out_data;
  logic [31:0] prdata;
  logic        pready;

  // operations waiting for the driver, results waiting for the block
  dqr_in_t  queued_ops[$];
  dqr_out_t predicted_results[$];

  // deque mirror
  logic [DATA_W-1:0] mirror_store[DEPTH];
  int unsigned       mirror_head;
  int unsigned       mirror_tail;
  int unsigned       mirror_count;
  logic [CAP_W-1:0]  mirror_cap;

  // driver pacing
  int unsigned idle_left  = 0;
  bit          drain_wait = 1'b0;
  bit          no_gaps    = 1'b0;

  // tallies
  int unsigned errors      = 0;
  int unsigned ops_sent    = 0;
  int unsigned results_got = 0;
  int unsigned refused_got = 0;
  int unsigned full_got    = 0;
  int unsigned cap_writes  = 0;
  int unsigned quiet_cycles = 0;

  double_ended_queue_ring_unit u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_data  (out_data),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  always #6 clk = ~clk;

  // empty the mirror, as reset and a capacity write do
  function automatic void mirror_clear();
    mirror_head  = 0;
    mirror_tail  = 0;
    mirror_count = 0;
  endfunction

  // apply one operation to the mirror and return the result it should give
  function automatic dqr_out_t deque_predict(dqr_in_t op);
    dqr_out_t    r;
    int unsigned cap;
    r   = '0;
    cap = (mirror_cap == 0) ? 1 : ((mirror_cap > DEPTH) ? DEPTH : mirror_cap);
    if (op.kind == KIND_PUSH_FRONT || op.kind == KIND_PUSH_REAR) begin
      if (mirror_count < cap) begin
        if (mirror_count == 0) begin
          // first entry always lands at slot 0
          mirror_head     = 0;
          mirror_tail     = 0;
          mirror_store[0] = op.push_value;
        end else if (op.kind == KIND_PUSH_FRONT) begin
          mirror_head = (mirror_head == 0) ? cap - 1 : mirror_head - 1;
          mirror_store[mirror_head] = op.push_value;
        end else begin
          mirror_tail = (mirror_tail + 1 >= cap) ? 0 : mirror_tail + 1;
          mirror_store[mirror_tail] = op.push_value;
        end
        mirror_count++;
        r.done_res = 1'b1;
      end
    end else if (mirror_count != 0) begin
      if (mirror_count == 1) begin
        mirror_clear();
      end else begin
        if (op.kind == KIND_POP_FRONT)
          mirror_head = (mirror_head + 1 >= cap) ? 0 : mirror_head + 1;
        else
          mirror_tail = (mirror_tail == 0) ? cap - 1 : mirror_tail - 1;
        mirror_count--;
      end
      r.done_res = 1'b1;
    end
    if (mirror_count == 0) begin
      r.front_value = '1;
      r.rear_value  = '1;
    end else begin
      r.front_value = mirror_store[mirror_head];
      r.rear_value  = mirror_store[mirror_tail];
    end
    r.is_empty = (mirror_count == 0);
    r.is_full  = (mirror_count == cap);
    return r;
  endfunction

  // field compare, first ten failures shown
  task automatic check_field(input string name, input logic [31:0] want,
                             input logic [31:0] got);
    if (want !== got) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %h got %h (result %0d)", name, want, got,
                 results_got);
    end
  endtask

  // operand mix with the signed extremes showing up often
  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic dqr_in_t make_op(input logic [KIND_W-1:0] kind,
                                      input logic [31:0] value);
    dqr_in_t op;
    op.kind       = kind;
    op.push_value = value;
    return op;
  endfunction

  // random operations in runs that fill, drain or churn the queue
  task automatic queue_random_ops(input int unsigned count);
    int unsigned run_left;
    int unsigned push_pct;
    logic        is_push;
    run_left = 0;
    push_pct = 50;
    repeat (count) begin
      if (run_left == 0) begin
        run_left = $urandom_range(4, 20);
        case ($urandom_range(0, 2))
          0:       push_pct = 80;
          1:       push_pct = 20;
          default: push_pct = 50;
        endcase
      end
      run_left--;
      is_push = ($urandom_range(1, 100) <= push_pct);
      if (is_push)
        queued_ops.push_back(make_op($urandom_range(0, 1) ? KIND_PUSH_FRONT : KIND_PUSH_REAR,
                                     pick_value()));
      else
        queued_ops.push_back(make_op($urandom_range(0, 1) ? KIND_POP_FRONT : KIND_POP_REAR,
                                     pick_value()));
    end
  endtask

  // block is idle once every queued operation has come back
  task automatic wait_idle();
    while (queued_ops.size() != 0 || start || predicted_results.size() != 0)
      @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // register write: setup then access, mirror follows at the access edge
  task automatic reg_write(input logic [1:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (addr == 2'(4 * REG_CAPACITY)) begin
      mirror_cap = data[CAP_W-1:0];
      mirror_clear();
    end
    cap_writes++;
  endtask

  // register read, data taken mid access cycle
  task automatic reg_read_check(input logic [1:0] addr);
    @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= addr;
    @(posedge clk);
    penable <= 1'b1;
    @(negedge clk);
    check_field("capacity read", {27'b0, mirror_cap}, {27'b0, prdata[CAP_W-1:0]});
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic set_capacity(input logic [CAP_W-1:0] cap);
    logic [31:0] word;
    word         = $urandom();
    word[CAP_W-1:0] = cap;
    wait_idle();
    reg_write(2'(4 * REG_CAPACITY), word);
    reg_read_check(2'(4 * REG_CAPACITY));
  endtask

  // driver: one operation transfer at a time, paced by random gaps
  always @(posedge clk) begin
    logic go;
    if (rst_n) begin
      go = start;
      if (start && !busy) begin
        predicted_results.push_back(deque_predict(in_data));
        ops_sent++;
        go = 1'b0;
      end
      if (!go) begin
        if (idle_left > 0) begin
          idle_left--;
        end else if (drain_wait && predicted_results.size() != 0) begin
          go = 1'b0;
        end else if (queued_ops.size() != 0) begin
          in_data <= queued_ops.pop_front();
          go = 1'b1;
          drain_wait = ($urandom_range(0, 39) == 0);
          if (no_gaps) begin
            idle_left = 0;
          end else begin
            case ($urandom_range(0, 99)) inside
              [0:49]:  idle_left = 0;
              [50:84]: idle_left = $urandom_range(1, 3);
              [85:96]: idle_left = $urandom_range(4, 10);
              default: idle_left = $urandom_range(20, 60);
            endcase
          end
        end
      end
      start <= go;
    end
  end

  // monitor: every result transfer is matched against the oldest prediction
  always @(posedge clk) begin
    dqr_out_t want;
    if (rst_n && out_valid) begin
      if (predicted_results.size() == 0) begin
        errors++;
        if (errors <= 10)
          $display("unexpected result %p", out_data);
      end else begin
        want = predicted_results.pop_front();
        check_field("done_res", {31'b0, want.done_res}, {31'b0, out_data.done_res});
        check_field("front_value", want.front_value, out_data.front_value);
        check_field("rear_value", want.rear_value, out_data.rear_value);
        check_field("is_empty", {31'b0, want.is_empty}, {31'b0, out_data.is_empty});
        check_field("is_full", {31'b0, want.is_full}, {31'b0, out_data.is_full});
        if (!want.done_res) refused_got++;
        if (want.is_full) full_got++;
      end
      results_got++;
    end
  end

  // watchdog on cycles with no transfer of any kind
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || (psel && penable))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
      $display("DONE: errors detected");
      $finish;
    end
  end

  // sequence: reset, directed corners, then random phases over several capacities
  initial begin
    logic [CAP_W-1:0] phase_caps[9];
    phase_caps = '{5'd1, 5'd3, 5'd16, 5'd31, 5'd5, 5'd17, 5'd0, 5'd8,
                   CAP_W'($urandom_range(1, 16))};

    foreach (mirror_store[i]) mirror_store[i] = '0;
    mirror_cap = CAP_RESET;
    mirror_clear();
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    reg_read_check(2'(4 * REG_CAPACITY));

    // reset capacity: pops on empty, first push, extremes at both ends, last pop
    queued_ops.push_back(make_op(KIND_POP_FRONT, 32'h1234_5678));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'hFFFF_FFFF));
    queued_ops.push_back(make_op(KIND_PUSH_FRONT, 32'h7FFF_FFFF));
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'h8000_0000));
    queued_ops.push_back(make_op(KIND_PUSH_FRONT, 32'hFFFF_FFFF));
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'h0000_0000));
    queued_ops.push_back(make_op(KIND_POP_FRONT, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_FRONT, 32'h0));
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'hA5A5_A5A5));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h5A5A_5A5A));

    // capacity two: wrap both ways and refused pushes when full
    set_capacity(5'd2);
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'h0000_0001));
    queued_ops.push_back(make_op(KIND_PUSH_FRONT, 32'h0000_0002));
    queued_ops.push_back(make_op(KIND_PUSH_FRONT, 32'h0000_0003));
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'h0000_0004));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_FRONT, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_FRONT, 32'h0));

    // zero capacity behaves as one entry
    set_capacity(5'd0);
    queued_ops.push_back(make_op(KIND_PUSH_FRONT, 32'hDEAD_BEEF));
    queued_ops.push_back(make_op(KIND_PUSH_REAR, 32'hCAFE_F00D));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h0));
    queued_ops.push_back(make_op(KIND_POP_REAR, 32'h0));

    // random phases; capacity writes land on a non-empty queue too
    foreach (phase_caps[p]) begin
      set_capacity(phase_caps[p]);
      no_gaps = (p == 2 || p == 6);
      queue_random_ops(50);
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d operations, %0d results (%0d refused, %0d full)",
             ops_sent, results_got, refused_got, full_got);
    $display("capacity written %0d times including 0, 1, 16 and out-of-range values",
             cap_writes);
    if (errors == 0 && predicted_results.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("%0d mismatches, %0d results never arrived", errors,
               predicted_results.size());
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
